FILE: rtl/playfair_digraph_encryptor_unit_macros.svh
// ----------------------------------------------------------------------------
// Playfair encryptor assertion macros
// Shared property wrappers used by the encryptor RTL. Both sample on clk
// and are disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PLAYFAIR_DIGRAPH_ENCRYPTOR_UNIT_MACROS_SVH
`define PLAYFAIR_DIGRAPH_ENCRYPTOR_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PDENC_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PDENC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/pdenc_pkg.sv
// ----------------------------------------------------------------------------
// Playfair encryptor package
// Letter codes, square geometry, shared types and small helper functions.
// ----------------------------------------------------------------------------
package pdenc_pkg;

    localparam int unsigned SIDE    = 5;
    localparam int unsigned CELLS   = SIDE * SIDE;
    localparam int unsigned LETTERS = 26;

    localparam logic [4:0] LETTER_X    = 5'd23;
    localparam logic [4:0] LETTER_Q    = 5'd16;
    localparam logic [4:0] LAST_LETTER = 5'(LETTERS - 1);
    localparam logic [2:0] LAST_INDEX  = 3'(SIDE - 1);
    localparam logic [2:0] FULL_ROW    = 3'(SIDE);

    typedef enum logic [1:0] {
        OP_KEY_LETTER  = 2'd0,
        OP_KEY_END     = 2'd1,
        OP_TEXT_LETTER = 2'd2,
        OP_TEXT_END    = 2'd3
    } op_t;

    // Position of a letter inside the square.
    typedef struct packed {
        logic [2:0] row;
        logic [2:0] col;
    } pos_t;

    // One placement: letter goes to cell, and the cell's position is
    // recorded for the letter.
    typedef struct packed {
        logic       en;
        logic [4:0] letter;
        logic [4:0] cell_idx;
        pos_t       pos;
    } wr_t;

    // Step one place along a row or column, wrapping at the square edge.
    function automatic logic [2:0] inc5(input logic [2:0] v);
        logic [2:0] r;
        r = (v == LAST_INDEX) ? 3'd0 : 3'(v + 3'd1);
        return r;
    endfunction

    // Row-major cell index, row * 5 + col.
    function automatic logic [4:0] cell_addr(input logic [2:0] row, input logic [2:0] col);
        logic [4:0] a;
        a = {row[2:0], 2'b00} + {2'b00, row} + {2'b00, col};
        return a;
    endfunction

endpackage

FILE: rtl/pdenc_place.sv
// ----------------------------------------------------------------------------
// Playfair square placement unit
// Decides whether a candidate letter enters the square and where. Keeps the
// placed flags and the next free position. Shared by key letters and by the
// key-end fill walk.
// ----------------------------------------------------------------------------
module pdenc_place
    import pdenc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       place_en,
    input  logic [4:0] place_letter,
    input  logic       clear,
    output wr_t        wr
);

    logic [LETTERS-1:0] placed_reg;
    logic [LETTERS-1:0] placed_next;
    logic [2:0]         fill_row_reg;
    logic [2:0]         fill_row_next;
    logic [2:0]         fill_col_reg;
    logic [2:0]         fill_col_next;
    logic               in_range;
    logic               full;
    logic               do_place;

    assign in_range = (place_letter <= LAST_LETTER);
    assign full     = (fill_row_reg == FULL_ROW);
    assign do_place = place_en && in_range && !full && !placed_reg[place_letter];

    assign wr.en       = do_place;
    assign wr.letter   = place_letter;
    assign wr.cell_idx = cell_addr(fill_row_reg, fill_col_reg);
    assign wr.pos.row  = fill_row_reg;
    assign wr.pos.col  = fill_col_reg;

    always_comb
    begin
        placed_next   = placed_reg;
        fill_row_next = fill_row_reg;
        fill_col_next = fill_col_reg;
        if (clear)
        begin
            placed_next   = '0;
            fill_row_next = 3'd0;
            fill_col_next = 3'd0;
        end
        else if (do_place)
        begin
            placed_next[place_letter] = 1'b1;
            if (fill_col_reg == LAST_INDEX)
            begin
                fill_col_next = 3'd0;
                fill_row_next = 3'(fill_row_reg + 3'd1);
            end
            else
            begin
                fill_col_next = 3'(fill_col_reg + 3'd1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            placed_reg   <= '0;
            fill_row_reg <= 3'd0;
            fill_col_reg <= 3'd0;
        end
        else
        begin
            placed_reg   <= placed_next;
            fill_row_reg <= fill_row_next;
            fill_col_reg <= fill_col_next;
        end
    end

endmodule

FILE: rtl/pdenc_rule.sv
// ----------------------------------------------------------------------------
// Playfair digraph rule
// Maps the square positions of two letters to the two ciphertext cells:
// same row shifts right, same column shifts down, else rectangle corners.
// ----------------------------------------------------------------------------
module pdenc_rule
    import pdenc_pkg::*;
(
    input  pos_t       pos_a,
    input  pos_t       pos_b,
    output logic [4:0] cell_a,
    output logic [4:0] cell_b
);

    always_comb
    begin
        priority if (pos_a.row == pos_b.row)
        begin
            cell_a = cell_addr(pos_a.row, inc5(pos_a.col));
            cell_b = cell_addr(pos_a.row, inc5(pos_b.col));
        end
        else if (pos_a.col == pos_b.col)
        begin
            cell_a = cell_addr(inc5(pos_a.row), pos_a.col);
            cell_b = cell_addr(inc5(pos_b.row), pos_a.col);
        end
        else
        begin
            cell_a = cell_addr(pos_a.row, pos_b.col);
            cell_b = cell_addr(pos_b.row, pos_a.col);
        end
    end

endmodule

FILE: rtl/pdenc_square.sv
// ----------------------------------------------------------------------------
// Playfair square storage
// Letter-position memory and cell memory, each with one write port and two
// registered read ports.
// ----------------------------------------------------------------------------
module pdenc_square
    import pdenc_pkg::*;
(
    input  logic       clk,
    input  wr_t        wr,
    input  logic       pos_rd_en,
    input  logic [4:0] pos_addr_a,
    input  logic [4:0] pos_addr_b,
    output pos_t       pos_a,
    output pos_t       pos_b,
    input  logic       cell_rd_en,
    input  logic [4:0] cell_addr_a,
    input  logic [4:0] cell_addr_b,
    output logic [4:0] cell_a,
    output logic [4:0] cell_b
);

    pos_t       pos_mem [LETTERS];
    logic [4:0] cell_mem [CELLS];
    pos_t       pos_a_reg;
    pos_t       pos_b_reg;
    logic [4:0] cell_a_reg;
    logic [4:0] cell_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            pos_mem[wr.letter]    <= wr.pos;
            cell_mem[wr.cell_idx] <= wr.letter;
        end
        if (pos_rd_en)
        begin
            pos_a_reg <= pos_mem[pos_addr_a];
            pos_b_reg <= pos_mem[pos_addr_b];
        end
        if (cell_rd_en)
        begin
            cell_a_reg <= cell_mem[cell_addr_a];
            cell_b_reg <= cell_mem[cell_addr_b];
        end
    end

    assign pos_a  = pos_a_reg;
    assign pos_b  = pos_b_reg;
    assign cell_a = cell_a_reg;
    assign cell_b = cell_b_reg;

endmodule

FILE: rtl/playfair_digraph_encryptor_unit.sv
// A pair result passes the position read and the cell read of the shared square,
// then S_EMIT loads it into the output register; other results go straight to S_EMIT.
// No new transaction is accepted until S_EMIT has loaded the result.
// The key-end fill walks all 26 letters past the placement unit, one per cycle, and skips q.
// Reset (rst_n low, asynchronous) clears the sequencer, held letter and placed flags;
// the square and the position memory are undefined until written by key placement.
// ----------------------------------------------------------------------------
// Playfair digraph encryptor
// Builds a 5x5 Playfair square from streamed key letters and encrypts the
// text letters that follow, two letters per pair result.
// ----------------------------------------------------------------------------
`include "playfair_digraph_encryptor_unit_macros.svh"

module playfair_digraph_encryptor_unit
    import pdenc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [4:0] letter, [7:5] zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [4:0] first_out, [9:5] second_out, [15:10] zero
    output logic [1:0]  m_axis_tuser,   // [0] pair_valid, [1] error
    output logic        m_axis_tlast    // message_end
);

    // The sequencer walks one item at a time. Text pairs go through the
    // position lookup (S_IDLE issues it), the cell lookup (S_CELL) and the
    // output load (S_EMIT). Key end walks the letters through S_FILL.
    typedef enum logic [2:0] {
        S_IDLE,
        S_FILL,
        S_CELL,
        S_EMIT
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    logic [4:0] walk_reg;
    logic [4:0] walk_next;
    logic [4:0] held_letter_reg;
    logic [4:0] held_letter_next;
    logic       held_valid_reg;
    logic       held_valid_next;
    logic       res_pair_reg;
    logic       res_pair_next;
    logic       res_end_reg;
    logic       res_end_next;
    logic       res_err_reg;
    logic       res_err_next;
    logic       m_valid_reg;
    logic       m_valid_next;
    logic [4:0] m_first_reg;
    logic [4:0] m_first_next;
    logic [4:0] m_second_reg;
    logic [4:0] m_second_next;
    logic       m_pair_reg;
    logic       m_pair_next;
    logic       m_end_reg;
    logic       m_end_next;
    logic       m_err_reg;
    logic       m_err_next;

    logic       s_accept;
    op_t        s_op;
    logic [4:0] s_letter;
    logic       s_in_range;

    logic       place_en;
    logic [4:0] place_letter;
    logic       place_clear;
    wr_t        wr;

    logic       pos_rd_en;
    logic [4:0] pos_addr_b;
    pos_t       pos_a;
    pos_t       pos_b;
    logic       cell_rd_en;
    logic [4:0] rule_cell_a;
    logic [4:0] rule_cell_b;
    logic [4:0] cell_a;
    logic [4:0] cell_b;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign s_op          = op_t'(s_axis_tuser);
    assign s_letter      = s_axis_tdata[4:0];
    assign s_in_range    = (s_letter <= LAST_LETTER);

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {6'd0, m_second_reg, m_first_reg};
    assign m_axis_tuser  = {m_err_reg, m_pair_reg};
    assign m_axis_tlast  = m_end_reg;

    // The placement unit is shared by single key letters and the fill walk.
    pdenc_place u_place (
        .clk          (clk),
        .rst_n        (rst_n),
        .place_en     (place_en),
        .place_letter (place_letter),
        .clear        (place_clear),
        .wr           (wr)
    );

    pdenc_square u_square (
        .clk         (clk),
        .wr          (wr),
        .pos_rd_en   (pos_rd_en),
        .pos_addr_a  (held_letter_reg),
        .pos_addr_b  (pos_addr_b),
        .pos_a       (pos_a),
        .pos_b       (pos_b),
        .cell_rd_en  (cell_rd_en),
        .cell_addr_a (rule_cell_a),
        .cell_addr_b (rule_cell_b),
        .cell_a      (cell_a),
        .cell_b      (cell_b)
    );

    pdenc_rule u_rule (
        .pos_a  (pos_a),
        .pos_b  (pos_b),
        .cell_a (rule_cell_a),
        .cell_b (rule_cell_b)
    );

    always_comb
    begin
        state_next       = state_reg;
        walk_next        = walk_reg;
        held_letter_next = held_letter_reg;
        held_valid_next  = held_valid_reg;
        res_pair_next    = res_pair_reg;
        res_end_next     = res_end_reg;
        res_err_next     = res_err_reg;
        m_valid_next     = m_valid_reg;
        m_first_next     = m_first_reg;
        m_second_next    = m_second_reg;
        m_pair_next      = m_pair_reg;
        m_end_next       = m_end_reg;
        m_err_next       = m_err_reg;
        place_en         = 1'b0;
        place_letter     = s_letter;
        place_clear      = 1'b0;
        pos_rd_en        = 1'b0;
        pos_addr_b       = LETTER_X;
        cell_rd_en       = 1'b0;

        // The downstream side drains the output register independently.
        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_accept)
                begin
                    unique case (s_op)
                        OP_KEY_LETTER:
                        begin
                            place_en = 1'b1;
                        end
                        OP_KEY_END:
                        begin
                            walk_next  = 5'd0;
                            state_next = S_FILL;
                        end
                        OP_TEXT_LETTER:
                        begin
                            if (s_in_range)
                            begin
                                if (!held_valid_reg)
                                begin
                                    held_letter_next = s_letter;
                                    held_valid_next  = 1'b1;
                                end
                                else
                                begin
                                    res_end_next = 1'b0;
                                    if ((held_letter_reg == LETTER_X) && (s_letter == LETTER_X))
                                    begin
                                        // A doubled x cannot be split; x stays held.
                                        res_pair_next = 1'b0;
                                        res_err_next  = 1'b1;
                                        state_next    = S_EMIT;
                                    end
                                    else
                                    begin
                                        res_pair_next = 1'b1;
                                        res_err_next  = 1'b0;
                                        pos_rd_en     = 1'b1;
                                        pos_addr_b    = (held_letter_reg == s_letter) ?
                                                        LETTER_X : s_letter;
                                        state_next    = S_CELL;
                                    end
                                    // A doubled letter keeps the second copy held.
                                    if (held_letter_reg != s_letter)
                                    begin
                                        held_valid_next = 1'b0;
                                    end
                                end
                            end
                        end
                        OP_TEXT_END:
                        begin
                            place_clear      = 1'b1;
                            held_valid_next  = 1'b0;
                            held_letter_next = 5'd0;
                            res_end_next     = 1'b1;
                            res_pair_next    = 1'b0;
                            res_err_next     = 1'b0;
                            state_next       = S_EMIT;
                            if (held_valid_reg)
                            begin
                                if (held_letter_reg == LETTER_X)
                                begin
                                    res_err_next = 1'b1;
                                end
                                else
                                begin
                                    // Pad the lone letter with x.
                                    res_pair_next = 1'b1;
                                    pos_rd_en     = 1'b1;
                                    state_next    = S_CELL;
                                end
                            end
                        end
                    endcase
                end
            end
            S_FILL:
            begin
                place_en     = (walk_reg != LETTER_Q);
                place_letter = walk_reg;
                if (walk_reg == LAST_LETTER)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    walk_next = 5'(walk_reg + 5'd1);
                end
            end
            S_CELL:
            begin
                cell_rd_en = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next  = 1'b1;
                    m_first_next  = res_pair_reg ? cell_a : 5'd0;
                    m_second_next = res_pair_reg ? cell_b : 5'd0;
                    m_pair_next   = res_pair_reg;
                    m_end_next    = res_end_reg;
                    m_err_next    = res_err_reg;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            walk_reg        <= 5'd0;
            held_letter_reg <= 5'd0;
            held_valid_reg  <= 1'b0;
            res_pair_reg    <= 1'b0;
            res_end_reg     <= 1'b0;
            res_err_reg     <= 1'b0;
            m_valid_reg     <= 1'b0;
            m_first_reg     <= 5'd0;
            m_second_reg    <= 5'd0;
            m_pair_reg      <= 1'b0;
            m_end_reg       <= 1'b0;
            m_err_reg       <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            walk_reg        <= walk_next;
            held_letter_reg <= held_letter_next;
            held_valid_reg  <= held_valid_next;
            res_pair_reg    <= res_pair_next;
            res_end_reg     <= res_end_next;
            res_err_reg     <= res_err_next;
            m_valid_reg     <= m_valid_next;
            m_first_reg     <= m_first_next;
            m_second_reg    <= m_second_next;
            m_pair_reg      <= m_pair_next;
            m_end_reg       <= m_end_next;
            m_err_reg       <= m_err_next;
        end
    end

    // The fill walk must hold off new transactions after a key end.
    `PDENC_ASSERT_NEXT(a_key_end_busy, s_accept && (s_op == OP_KEY_END), !s_axis_tready, "key end did not start the fill walk")

    // A result is either an encrypted pair or an error, never both.
    `PDENC_ASSERT_IMPLY(a_pair_err_excl, m_axis_tvalid, !(m_axis_tuser[0] && m_axis_tuser[1]), "pair and error flagged together")

    // Results without a pair carry zero letters.
    `PDENC_ASSERT_IMPLY(a_no_pair_zero, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata == 16'd0, "letters present without a pair")

endmodule
